>>> hw/rtl/ftt_pkg.sv
// Shared types and constants for the feature track table.
// Holds operation codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package ftt_pkg;

  // Fixed field widths of the streaming payloads
  localparam int OP_W        = 3;
  localparam int IMG_FIELD_W = 16;
  localparam int PT_FIELD_W  = 20;
  localparam int IDX_FIELD_W = 6;
  localparam int OUT_PT_W    = 21;
  localparam int OUT_CNT_W   = 7;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 72;

  localparam int COUNT_W = 16;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 16'sh7fff;
  localparam logic signed [COUNT_W-1:0] COUNT_BAD  = -16'sd1;
  localparam logic [OUT_PT_W-1:0]       PT_ABSENT  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_CONTAINS = 3'd1,
    OP_PAIR     = 3'd2,
    OP_READ     = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_POST,
    ST_READ_WAIT,
    ST_APPEND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;      // latch the incoming item
    logic start;     // reset scan and result registers
    logic clear;     // empty the table
    logic scan;      // issue one read and compare returned entry
    logic read_idx;  // read entry at the requested index
    logic capture;   // take read data as the result
    logic append;    // write the item at the end of the table
    logic emit;      // load the output register
  } ftt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_neg;
    logic            total_zero;
    logic            idx_valid;
    logic            scan_done;
    logic            need_append;
    logic            out_free;
  } ftt_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ftt_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module ftt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ftt_ctrl.sv
// Controller state machine for the feature track table.
// Depends on ftt_pkg; drives the datapath only through ftt_cmd_t.
`default_nettype none

module ftt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire ftt_pkg::ftt_sts_t sts,
  output ftt_pkg::ftt_cmd_t      cmd
);

  ftt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ftt_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = ftt_pkg::ST_START;
      end
      ftt_pkg::ST_START: begin
        unique case (sts.op) inside
          ftt_pkg::OP_ADD: begin
            if (sts.count_neg || sts.total_zero) state_next = ftt_pkg::ST_APPEND;
            else                                 state_next = ftt_pkg::ST_SCAN;
          end
          ftt_pkg::OP_CONTAINS, ftt_pkg::OP_PAIR: begin
            state_next = sts.total_zero ? ftt_pkg::ST_FINISH : ftt_pkg::ST_SCAN;
          end
          ftt_pkg::OP_READ: begin
            state_next = sts.idx_valid ? ftt_pkg::ST_READ_WAIT : ftt_pkg::ST_FINISH;
          end
          default: state_next = ftt_pkg::ST_FINISH;
        endcase
      end
      ftt_pkg::ST_SCAN: begin
        if (sts.scan_done) state_next = ftt_pkg::ST_POST;
      end
      ftt_pkg::ST_POST: begin
        state_next = sts.need_append ? ftt_pkg::ST_APPEND : ftt_pkg::ST_FINISH;
      end
      ftt_pkg::ST_READ_WAIT: state_next = ftt_pkg::ST_FINISH;
      ftt_pkg::ST_APPEND:    state_next = ftt_pkg::ST_FINISH;
      ftt_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = ftt_pkg::ST_IDLE;
      end
      default: state_next = ftt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ftt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ftt_pkg::ST_START: begin
        cmd.start    = 1'b1;
        cmd.clear    = (sts.op == ftt_pkg::OP_CLEAR);
        cmd.read_idx = (sts.op == ftt_pkg::OP_READ) && sts.idx_valid;
      end
      ftt_pkg::ST_SCAN:      cmd.scan    = 1'b1;
      ftt_pkg::ST_POST:      cmd         = '0;
      ftt_pkg::ST_READ_WAIT: cmd.capture = 1'b1;
      ftt_pkg::ST_APPEND:    cmd.append  = 1'b1;
      ftt_pkg::ST_FINISH:    cmd.emit    = sts.out_free;
      default:               cmd         = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/ftt_dp.sv
// Datapath for the feature track table: item registers, table RAM,
// scan pointer, compare logic, counters and the output register.
// Depends on ftt_pkg and ftt_ram.
`default_nettype none

module ftt_dp #(
  parameter int MAX_VIEWS  = 64,
  parameter int IMAGE_BITS = 16,
  parameter int POINT_BITS = 20,
  localparam int AW = $clog2(MAX_VIEWS),
  localparam int CW = $clog2(MAX_VIEWS + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ftt_pkg::ftt_cmd_t                 cmd,
  output ftt_pkg::ftt_sts_t                      sts,
  input  wire logic [ftt_pkg::OP_W-1:0]          op,
  input  wire logic [ftt_pkg::IMG_FIELD_W-1:0]   image,
  input  wire logic [ftt_pkg::PT_FIELD_W-1:0]    point,
  input  wire logic [ftt_pkg::IMG_FIELD_W-1:0]   pair_image,
  input  wire logic [ftt_pkg::IDX_FIELD_W-1:0]   entry_index,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   ok,
  output logic [ftt_pkg::OUT_PT_W-1:0]           first_point,
  output logic [ftt_pkg::OUT_PT_W-1:0]           second_point,
  output logic [ftt_pkg::IMG_FIELD_W-1:0]        entry_image,
  output logic                                   table_full,
  output logic [ftt_pkg::OUT_CNT_W-1:0]          entry_count
);

  localparam int RW = IMAGE_BITS + POINT_BITS + 1;

  // Item registers
  logic [ftt_pkg::OP_W-1:0]        op_q;
  logic [IMAGE_BITS-1:0]           img_q;
  logic [POINT_BITS-1:0]           pt_q;
  logic [IMAGE_BITS-1:0]           img2_q;
  logic [ftt_pkg::IDX_FIELD_W-1:0] idx_q;

  // Table state
  logic [CW-1:0]                       total;
  logic signed [ftt_pkg::COUNT_W-1:0]  count;

  // Scan state
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic          found;
  logic          one_hit;

  // Result registers
  logic                            res_ok;
  logic [ftt_pkg::OUT_PT_W-1:0]    res_first;
  logic [ftt_pkg::OUT_PT_W-1:0]    res_second;
  logic [ftt_pkg::IMG_FIELD_W-1:0] res_eimg;
  logic                            res_full;

  // RAM interface
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic                  q_good;
  logic [POINT_BITS-1:0] q_pt;
  logic [IMAGE_BITS-1:0] q_img;
  logic                  m_img, m_pt, m_img2;
  logic                  is_full;
  logic                  stop;
  logic                  more;

  assign q_good = ram_rdata[0];
  assign q_pt   = ram_rdata[POINT_BITS:1];
  assign q_img  = ram_rdata[RW-1:POINT_BITS+1];

  assign m_img   = (q_img == img_q);
  assign m_pt    = (q_pt == pt_q);
  assign m_img2  = (q_img == img2_q);
  assign is_full = (total == CW'(MAX_VIEWS));
  assign more    = (rd_idx < total);

  always_comb begin
    stop = 1'b0;
    if (pend) begin
      case (op_q)
        ftt_pkg::OP_ADD:      stop = m_img;
        ftt_pkg::OP_CONTAINS: stop = m_img && m_pt;
        ftt_pkg::OP_PAIR:     stop = (m_img && m_img2) || ((m_img || m_img2) && one_hit);
        default:              stop = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (cmd.append) begin
      ram_addr = total[AW-1:0];
    end else if (cmd.read_idx) begin
      ram_addr = AW'(idx_q);
    end else begin
      ram_addr = rd_idx[AW-1:0];
    end
  end

  assign ram_we    = cmd.append && !is_full;
  assign ram_wdata = {img_q, pt_q, ~count[ftt_pkg::COUNT_W-1]};

  ftt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VIEWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts             = '0;
    sts.op          = op_q;
    sts.count_neg   = count[ftt_pkg::COUNT_W-1];
    sts.total_zero  = (total == '0);
    sts.idx_valid   = (32'(idx_q) < 32'(total));
    sts.scan_done   = stop || (!pend && !more);
    sts.need_append = (op_q == ftt_pkg::OP_ADD) && !found;
    sts.out_free    = !out_valid || out_ready;
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      img_q  <= IMAGE_BITS'(image);
      pt_q   <= POINT_BITS'(point);
      img2_q <= IMAGE_BITS'(pair_image);
      idx_q  <= entry_index;
    end
  end

  // Control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      count   <= '0;
      rd_idx  <= '0;
      pend    <= 1'b0;
      found   <= 1'b0;
      one_hit <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_idx  <= '0;
        pend    <= 1'b0;
        found   <= 1'b0;
        one_hit <= 1'b0;
      end
      if (cmd.clear) begin
        total <= '0;
        count <= '0;
      end
      if (cmd.scan) begin
        if (more) begin
          rd_idx <= rd_idx + CW'(1);
          pend   <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (pend && op_q == ftt_pkg::OP_ADD && m_img) begin
          found <= 1'b1;
          if (!m_pt) begin
            count <= ftt_pkg::COUNT_BAD;
          end else if (count != ftt_pkg::COUNT_MAX) begin
            count <= count + 16'sd1;
          end
        end
        if (pend && op_q == ftt_pkg::OP_PAIR && (m_img || m_img2)) begin
          one_hit <= 1'b1;
        end
      end
      if (cmd.append && !is_full) begin
        total <= total + CW'(1);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_ok     <= 1'b0;
      res_first  <= ftt_pkg::PT_ABSENT;
      res_second <= ftt_pkg::PT_ABSENT;
      res_eimg   <= '0;
      res_full   <= 1'b0;
    end
    if (cmd.scan && pend) begin
      if (op_q == ftt_pkg::OP_CONTAINS && m_img && m_pt) begin
        res_ok <= q_good;
      end
      if (op_q == ftt_pkg::OP_PAIR) begin
        if (m_img) begin
          res_first <= ftt_pkg::OUT_PT_W'(q_pt);
        end
        // Second image is skipped when the first image already gave the second hit
        if (m_img2 && !(m_img && one_hit)) begin
          res_second <= ftt_pkg::OUT_PT_W'(q_pt);
        end
      end
    end
    if (cmd.capture) begin
      res_ok    <= 1'b1;
      res_first <= ftt_pkg::OUT_PT_W'(q_pt);
      res_eimg  <= ftt_pkg::IMG_FIELD_W'(q_img);
    end
    if (cmd.append && is_full) begin
      res_full <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ok           <= (op_q == ftt_pkg::OP_ADD) ? ~count[ftt_pkg::COUNT_W-1] : res_ok;
      first_point  <= res_first;
      second_point <= res_second;
      entry_image  <= res_eimg;
      table_full   <= res_full;
      entry_count  <= ftt_pkg::OUT_CNT_W'(total);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/feature_track_table.sv
// Sequencing: an add, contains or pair lookup scans up to the N stored entries before its
// result; read entry reads the indexed entry; clear and unused ops go straight to the result.
// Throughput: one item at a time, a new item being taken only once the last has finished;
// the scan is set by the single table RAM port, which it walks one entry per cycle.
// Reset (rst, synchronous): empties the table, zeroes the consistency count and drops
// any pending result; table contents are left as they are and are never read unwritten.
//
// Top level of the feature track table: one track of (image, point) entries with good
// flags and a signed consistency count. Depends on ftt_pkg, ftt_ctrl, ftt_dp, ftt_ram.
`default_nettype none

module feature_track_table #(
  parameter int MAX_VIEWS  = 64,
  parameter int IMAGE_BITS = 16,
  parameter int POINT_BITS = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // tdata: image[15:0], point[35:16], pair_image[51:36], entry_index[57:52], zero[63:58]
  input  wire logic [ftt_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: op[2:0]
  input  wire logic [ftt_pkg::OP_W-1:0]        s_tuser,
  // Result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // tdata: ok[0], first_point[21:1], second_point[42:22], entry_image[58:43],
  //        table_full[59], entry_count[66:60], zero[71:67]
  output logic [ftt_pkg::OUT_DATA_W-1:0]       m_tdata
);

  ftt_pkg::ftt_cmd_t cmd;
  ftt_pkg::ftt_sts_t sts;

  // Unpacked input fields
  logic [ftt_pkg::IMG_FIELD_W-1:0] in_image;
  logic [ftt_pkg::PT_FIELD_W-1:0]  in_point;
  logic [ftt_pkg::IMG_FIELD_W-1:0] in_pair_image;
  logic [ftt_pkg::IDX_FIELD_W-1:0] in_entry_index;

  // Result fields from the output register
  logic                            ok;
  logic [ftt_pkg::OUT_PT_W-1:0]    first_point;
  logic [ftt_pkg::OUT_PT_W-1:0]    second_point;
  logic [ftt_pkg::IMG_FIELD_W-1:0] entry_image;
  logic                            table_full;
  logic [ftt_pkg::OUT_CNT_W-1:0]   entry_count;

  assign in_image       = s_tdata[15:0];
  assign in_point       = s_tdata[35:16];
  assign in_pair_image  = s_tdata[51:36];
  assign in_entry_index = s_tdata[57:52];

  // Controller: sequences one transaction at a time through start, then scan, read or append, and emit
  ftt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: the output register lets the next transaction in while a result waits
  ftt_dp #(
    .MAX_VIEWS  (MAX_VIEWS),
    .IMAGE_BITS (IMAGE_BITS),
    .POINT_BITS (POINT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (s_tuser),
    .image        (in_image),
    .point        (in_point),
    .pair_image   (in_pair_image),
    .entry_index  (in_entry_index),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .ok           (ok),
    .first_point  (first_point),
    .second_point (second_point),
    .entry_image  (entry_image),
    .table_full   (table_full),
    .entry_count  (entry_count)
  );

  // Pack the result, first field in the lowest bits, pad to whole bytes
  assign m_tdata = {5'b0, entry_count, table_full, entry_image, second_point,
                    first_point, ok};

endmodule

`default_nettype wire

>>> hw/rtl/ftt_checker.sv
// Port-level checks for the feature track table, bound to the top level.
// Depends on feature_track_table's port list only.
`default_nettype none

module ftt_checker #(
  parameter int MAX_VIEWS = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);

  localparam logic [6:0]  FULL_COUNT = 7'(MAX_VIEWS);
  localparam logic [20:0] ABSENT     = '1;

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A dropped append only happens on a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[59] |-> m_tdata[66:60] == FULL_COUNT)
    else $error("table_full with room left");

  // Only pair lookup gives a second point, and it never sets ok or an entry image
  a_second_only_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[42:22] != ABSENT |-> !m_tdata[0] && m_tdata[58:43] == 16'd0)
    else $error("second point with ok or entry image");

  // An entry image only comes from a valid read
  a_image_from_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[58:43] != 16'd0 |-> m_tdata[0])
    else $error("entry image without ok");

endmodule

bind feature_track_table ftt_checker #(.MAX_VIEWS(MAX_VIEWS)) u_ftt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
